>>> hw/rtl/prwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prwl_pkg
// Shared types and constants for the priority ready/wait list unit.
// ----------------------------------------------------------------------------
package prwl_pkg;

	localparam int unsigned TASKS_DEF  = 32;
	localparam int unsigned LEVELS_DEF = 32;
	localparam int unsigned FUNC_W     = 3;
	localparam int unsigned ID_W       = 5;
	localparam int unsigned LVL_W      = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_INS_RDY  = 3'd0,
		FN_INS_WAIT = 3'd1,
		FN_REM_RDY  = 3'd2,
		FN_REM_WAIT = 3'd3,
		FN_MV_R2W   = 3'd4,
		FN_MV_W2R   = 3'd5,
		FN_RSVD6    = 3'd6,
		FN_RSVD7    = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		WH_NONE = 2'd0,
		WH_RDY  = 2'd1,
		WH_WAIT = 2'd2,
		WH_RSVD = 2'd3
	} where_t;

endpackage

>>> hw/rtl/priority_ready_wait_lists_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_wait_lists_unit
// Ready and wait task tables, one FIFO list per priority level, held in
// link memories (next, prev, level) and a per-list tail memory.
//
//  channel   signals                                   dir
//  command   start, func, task_id, level                 in
//  result    busy, done, status, highest_*_level, *_nonempty out
//
// A command goes through the sequencer states scan and done when rejected;
// an insert first runs append and append-tail, a remove read and unlink, a
// move all four. Each state does one access per link memory per cycle.
// busy is high from acceptance through the done cycle. Results cannot be
// stalled. After reset nothing needs clearing: occupancy bits (which mark
// list heads valid) and task locations are flip-flops reset at once.
// ----------------------------------------------------------------------------
module priority_ready_wait_lists_unit #(
	parameter int unsigned TASKS  = prwl_pkg::TASKS_DEF,
	parameter int unsigned LEVELS = prwl_pkg::LEVELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [prwl_pkg::FUNC_W-1:0] func,
	input  logic [prwl_pkg::ID_W-1:0]   task_id,
	input  logic [prwl_pkg::LVL_W-1:0]  level,
	output logic                       done,
	output logic                       status,
	output logic [prwl_pkg::LVL_W-1:0]  highest_ready_level,
	output logic                       ready_nonempty,
	output logic [prwl_pkg::LVL_W-1:0]  highest_wait_level,
	output logic                       wait_nonempty
);

	localparam int unsigned TW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int unsigned SW = LW + 1;
	localparam int unsigned NSLOT = 1 << SW;
	localparam int unsigned OW = prwl_pkg::LVL_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_UNL_P, ST_UNL_N, ST_APP, ST_APP_T, ST_APP_S, ST_SCAN, ST_DONE
	} state_t;

	state_t state_q;
	logic [TW-1:0] id_q;
	logic [LW-1:0] lvl_q;
	logic          tbl_q;
	logic          do_app_q;
	logic          status_q;
	logic [TW:0]   p_q, n_q;
	logic [1:0]    where_q [TASKS];
	logic [LEVELS-1:0] occ_q [2];
	logic [OW-1:0] last_q [2];

	// next memory
	logic          nx_we;
	logic [TW-1:0] nx_wa, nx_ra;
	logic [TW:0]   nx_wd, nx_rd;
	// prev memory
	logic          pv_we;
	logic [TW-1:0] pv_wa;
	logic [TW:0]   pv_wd, pv_rd;
	// level memory
	logic          lv_we;
	logic [LW-1:0] lv_rd;
	// tail memory
	logic          tl_we;
	logic [SW-1:0] tl_wa, tl_ra;
	logic [TW-1:0] tl_wd, tl_rd;

	prwl_ram #(.WIDTH(TW+1), .DEPTH(TASKS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
	prwl_ram #(.WIDTH(TW+1), .DEPTH(TASKS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(nx_ra), .rdata(pv_rd));
	prwl_ram #(.WIDTH(LW), .DEPTH(TASKS)) u_lvl (
		.clk(clk), .we(lv_we), .waddr(id_q), .wdata(lvl_q), .raddr(nx_ra), .rdata(lv_rd));
	prwl_ram #(.WIDTH(TW), .DEPTH(NSLOT)) u_tail (
		.clk(clk), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));

	logic [prwl_pkg::FUNC_W-1:0] fn_in;
	logic [TW-1:0] id_in;
	logic [LW-1:0] lvl_in;
	logic          id_ok;
	logic [1:0]    wh_in;
	logic [1:0]    wh_from;
	logic [SW-1:0] slot;
	logic          head_vld;

	assign fn_in    = func;
	assign id_ok    = (32'(task_id) < TASKS);
	assign id_in    = TW'(task_id);
	assign lvl_in   = (32'(level) >= LEVELS) ? LW'(LEVELS - 1) : LW'(level);
	assign wh_in    = where_q[id_in];
	assign wh_from  = fn_in[0] ? prwl_pkg::WH_WAIT : prwl_pkg::WH_RDY;
	assign slot     = {tbl_q, lvl_q};
	assign head_vld = occ_q[tbl_q][lvl_q];
	assign nx_ra    = (state_q == ST_IDLE) ? id_in : id_q;

	// tail read address is set in the state before each append state that uses it
	always_comb begin
		if (state_q == ST_IDLE) begin
			tl_ra = {fn_in[0], lvl_in};
		end else if (state_q == ST_UNL_P) begin
			tl_ra = {~tbl_q, lvl_q};
		end else begin
			tl_ra = slot;
		end
	end

	always_comb begin
		nx_we = 1'b0; nx_wa = id_q; nx_wd = '0;
		pv_we = 1'b0; pv_wa = id_q; pv_wd = '0;
		lv_we = 1'b0;
		tl_we = 1'b0; tl_wa = slot; tl_wd = id_q;
		unique case (state_q)
			ST_UNL_P: begin
				if (p_q[TW]) begin
					nx_we = 1'b1; nx_wa = p_q[TW-1:0]; nx_wd = n_q;
				end
				if (n_q[TW]) begin
					pv_we = 1'b1; pv_wa = n_q[TW-1:0]; pv_wd = p_q;
				end
				if (!n_q[TW] && p_q[TW]) begin
					tl_we = 1'b1; tl_wd = p_q[TW-1:0];
				end
			end
			ST_APP: begin
				nx_we = 1'b1; nx_wa = id_q; nx_wd = '0;
				lv_we = 1'b1;
				pv_we = 1'b1; pv_wa = id_q;
				pv_wd = head_vld ? {1'b1, tl_rd} : '0;
			end
			ST_APP_T: begin
				nx_we = head_vld; nx_wa = tl_rd;
				nx_wd = {1'b1, id_q};
				tl_we = 1'b1; tl_wd = id_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= 1'b0;
			done     <= 1'b0;
			for (int i = 0; i < TASKS; i++) where_q[i] <= prwl_pkg::WH_NONE;
			occ_q[0] <= '0; occ_q[1] <= '0;
			last_q[0] <= '0; last_q[1] <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && !busy) begin
						id_q     <= id_in;
						lvl_q    <= lvl_in;
						do_app_q <= 1'b0;
						status_q <= 1'b1;
						state_q  <= ST_SCAN;
						if (id_ok) begin
							unique case (prwl_pkg::func_t'(fn_in))
								prwl_pkg::FN_INS_RDY, prwl_pkg::FN_INS_WAIT: begin
									tbl_q <= fn_in[0];
									if (wh_in == prwl_pkg::WH_NONE) begin
										status_q <= 1'b0; do_app_q <= 1'b1;
										state_q  <= ST_APP;
									end
								end
								prwl_pkg::FN_REM_RDY, prwl_pkg::FN_REM_WAIT: begin
									tbl_q <= fn_in[0];
									if (wh_in == wh_from) begin
										status_q <= 1'b0;
										state_q  <= ST_RD;
									end
								end
								prwl_pkg::FN_MV_R2W, prwl_pkg::FN_MV_W2R: begin
									tbl_q <= fn_in[0];
									if (wh_in == wh_from) begin
										status_q <= 1'b0;
										do_app_q <= 1'b1; state_q <= ST_RD;
									end
								end
								default: ;
							endcase
						end
					end
				end
				ST_RD: begin
					p_q   <= pv_rd;
					n_q   <= nx_rd;
					lvl_q <= lv_rd;
					state_q <= ST_UNL_P;
				end
				ST_UNL_P: begin
					if (!p_q[TW] && !n_q[TW]) occ_q[tbl_q][lvl_q] <= 1'b0;
					where_q[id_q] <= prwl_pkg::WH_NONE;
					if (do_app_q) begin
						tbl_q   <= ~tbl_q;
						state_q <= ST_APP;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_APP: begin
					state_q <= ST_APP_T;
				end
				ST_APP_T: begin
					if (!head_vld) occ_q[tbl_q][lvl_q] <= 1'b1;
					where_q[id_q] <= tbl_q ? prwl_pkg::WH_WAIT : prwl_pkg::WH_RDY;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// priority encode both occupancy vectors
					for (int t = 0; t < 2; t++) begin
						for (int i = LEVELS - 1; i >= 0; i--) begin
							if (occ_q[t][i]) last_q[t] <= OW'(i);
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy                = (state_q != ST_IDLE) || done;
	assign status              = status_q;
	assign highest_ready_level = last_q[0];
	assign highest_wait_level  = last_q[1];
	assign ready_nonempty      = |occ_q[0];
	assign wait_nonempty       = |occ_q[1];

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while not busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> busy) else $error("busy low while working");

endmodule

>>> hw/rtl/prwl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prwl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prwl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
